// ===== hw/rtl/array_list_engine_core_macros.svh =====
// ---------------------------------------------------------------------------
// array list engine assertion macros
// shorthand for clocked, reset-qualified concurrent assertions
// ---------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define ALE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("array list engine check failed");

// next-cycle implication
`define ALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("array list engine check failed");

`endif

// ===== hw/rtl/ale_pkg.sv =====
// ---------------------------------------------------------------------------
// ale_pkg
// shared types and codes for the array list engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_FIND,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         position;
        logic signed [31:0] element_value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [6:0]         found_position;
        logic signed [31:0] read_value;
        logic [7:0]         count_after;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/array_list_engine_core.sv =====
// ---------------------------------------------------------------------------
// array_list_engine_core
// dense ordered list of signed 32-bit values with append, insert, delete,
// find and read requests, one result transaction per request
// ---------------------------------------------------------------------------
// One request is handled at a time. Append, read and rejected requests do
// not walk. Insert, delete and find walk the stored entries one a cycle
// through the entry memory, which has one read and one write port, stepped
// by one shared pointer unit. The longest request is a find that misses in
// a full list. A finished result sits in an output register, so the next
// request is taken while it waits. Entries are not cleared at reset; only
// the count is, and positions at or beyond the count are never used.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine_core #(
    parameter int DEPTH = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_op,
    input  wire logic [6:0]         s_position,
    input  wire logic signed [31:0] s_element_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [6:0]              m_found_position,
    output logic signed [31:0]      m_read_value,
    output logic [7:0]              m_count_after
);

    import ale_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int EXTW = (CW > 8) ? CW : 8;

    req_t          req;
    rsp_t          rsp;
    logic          rsp_valid;
    logic          rsp_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    logic          m_valid_reg, m_valid_next;
    rsp_t          m_rsp_reg;

    assign req.op            = s_op;
    assign req.position      = s_position;
    assign req.element_value = s_element_value;

    ale_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW),
        .EXTW  (EXTW)
    ) u_ale_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ale_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ale_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (rsp_valid && rsp_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_valid && rsp_ready) begin
            m_rsp_reg <= rsp;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_rsp_reg.status;
    assign m_found_position = m_rsp_reg.found_position;
    assign m_read_value     = m_rsp_reg.read_value;
    assign m_count_after    = m_rsp_reg.count_after;

endmodule

`default_nettype wire

// ===== hw/rtl/ale_mem.sv =====
// ---------------------------------------------------------------------------
// ale_mem
// entry store: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ale_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [31:0]       wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic [31:0]            rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ale_step.sv =====
// ---------------------------------------------------------------------------
// ale_step
// shared walk unit: steps the entry pointer and tests it against the limit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ale_step #(
    parameter int W = 8
) (
    input  wire logic [W-1:0] ptr,
    input  wire logic [W-1:0] limit,
    output logic [W-1:0]      ptr_inc,
    output logic [W-1:0]      ptr_dec,
    output logic              active
);

    assign ptr_inc = W'(ptr + 1'b1);
    assign ptr_dec = W'(ptr - 1'b1);
    assign active  = (ptr != limit);

endmodule

`default_nettype wire

// ===== hw/rtl/ale_ctrl.sv =====
// ---------------------------------------------------------------------------
// ale_ctrl
// request sequencer: checks, entry walks for insert, delete and find
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ale_ctrl #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int CW    = 8,
    parameter int EXTW  = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ale_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ale_pkg::rsp_t      rsp,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [31:0]        mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  wire logic [31:0]   mem_rdata
);

    import ale_pkg::*;

    state_t            state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [EXTW-1:0]   pos_reg, pos_next;
    logic [31:0]       val_reg, val_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [EXTW-1:0]   ptr_reg, ptr_next;
    logic [EXTW-1:0]   limit_reg, limit_next;
    logic              down_reg, down_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     tag_reg, tag_next;
    rsp_t              res_reg, res_next;

    logic [EXTW-1:0]   step_inc, step_dec;
    logic              step_active;
    logic [EXTW-1:0]   count_ext;
    logic              full;

    ale_step #(.W(EXTW)) u_ale_step (
        .ptr     (ptr_reg),
        .limit   (limit_reg),
        .ptr_inc (step_inc),
        .ptr_dec (step_dec),
        .active  (step_active)
    );

    assign count_ext = EXTW'(count_reg);
    assign full      = (count_ext == EXTW'(DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        ptr_reg   <= ptr_next;
        limit_reg <= limit_next;
        down_reg  <= down_next;
        tag_reg   <= tag_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        limit_next = limit_reg;
        down_next  = down_reg;
        pend_next  = pend_reg;
        tag_next   = tag_reg;
        res_next   = res_reg;

        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = tag_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = AW'(ptr_reg);

        unique case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next    = req.op;
                    pos_next   = EXTW'(req.position);
                    val_next   = req.element_value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_next.status         = ST_OK;
                res_next.found_position = '0;
                res_next.read_value     = '0;
                res_next.count_after    = '0;
                pend_next               = 1'b0;
                state_next              = S_DONE;
                unique case (op_reg)
                    OP_APPEND: begin
                        if (full) begin
                            res_next.status = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(count_reg);
                            mem_wdata  = val_reg;
                            count_next = CW'(count_reg + 1'b1);
                        end
                    end
                    OP_INSERT: begin
                        if (full) begin
                            res_next.status = ST_FULL;
                        end else if (pos_reg > count_ext) begin
                            res_next.status = ST_BAD_POS;
                        end else begin
                            // walk down from the end, moving each entry up one place
                            ptr_next   = count_ext;
                            limit_next = pos_reg;
                            down_next  = 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_DELETE: begin
                        if (pos_reg >= count_ext) begin
                            res_next.status = ST_BAD_POS;
                        end else begin
                            ptr_next   = EXTW'(pos_reg + 1'b1);
                            limit_next = count_ext;
                            down_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_FIND: begin
                        res_next.status = ST_NOT_FOUND;
                        ptr_next        = '0;
                        limit_next      = count_ext;
                        state_next      = S_FIND;
                    end
                    OP_READ: begin
                        if (pos_reg >= count_ext) begin
                            res_next.status = ST_BAD_POS;
                        end else begin
                            mem_raddr  = AW'(pos_reg);
                            state_next = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_SHIFT: begin
                mem_raddr = down_reg ? AW'(step_dec) : AW'(ptr_reg);
                // data read last cycle lands one place up or down
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = tag_reg;
                    mem_wdata = mem_rdata;
                end
                if (step_active) begin
                    ptr_next  = down_reg ? step_dec : step_inc;
                    tag_next  = down_reg ? AW'(ptr_reg) : AW'(step_dec);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (down_reg) begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(pos_reg);
                            mem_wdata  = val_reg;
                            count_next = CW'(count_reg + 1'b1);
                        end else begin
                            count_next = CW'(count_reg - 1'b1);
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_FIND: begin
                mem_raddr = AW'(ptr_reg);
                if (pend_reg && (mem_rdata == val_reg)) begin
                    res_next.status         = ST_OK;
                    res_next.found_position = 7'(tag_reg);
                    pend_next               = 1'b0;
                    state_next              = S_DONE;
                end else if (step_active) begin
                    ptr_next  = step_inc;
                    tag_next  = AW'(ptr_reg);
                    pend_next = 1'b1;
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_READ: begin
                res_next.read_value = mem_rdata;
                state_next          = S_DONE;
            end

            S_DONE: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        rsp             = res_reg;
        rsp.count_after = 8'(count_reg);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ale_checker.sv =====
// ---------------------------------------------------------------------------
// ale_checker
// port-level checks on the array list engine, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "array_list_engine_core_macros.svh"

module ale_checker #(
    parameter int DEPTH = 128
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [2:0]         s_op,
    input wire logic [6:0]         s_position,
    input wire logic signed [31:0] s_element_value,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [1:0]         m_status,
    input wire logic [6:0]         m_found_position,
    input wire logic signed [31:0] m_read_value,
    input wire logic [7:0]         m_count_after
);

    import ale_pkg::*;

    // a waiting result transaction holds
    `ALE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_count_after) && $stable(m_status))

    // one request in flight: no second transaction straight after one is taken
    `ALE_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // a miss carries neither a position nor a value
    `ALE_ASSERT_SAME(a_not_found_clean, m_valid && (m_status == ST_NOT_FOUND), (m_found_position == 7'd0) && (m_read_value == 32'sd0))

    // full is only reported with the store at capacity
    `ALE_ASSERT_SAME(a_full_count, m_valid && (m_status == ST_FULL), m_count_after == 8'(DEPTH))

endmodule

bind array_list_engine_core ale_checker #(.DEPTH(DEPTH)) u_ale_checker (.*);

`default_nettype wire

// ===== tb/array_list_engine_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// array_list_engine_core_test
// Self-checking bench for the array list engine. A behavioural copy of the
// list predicts every result transaction. Directed requests cover the empty
// list, value and position extremes and the unused op codes. Random traffic
// then fills the list to capacity and drains it again, under three idling
// patterns and one long receiver hold-off.
// ---------------------------------------------------------------------------
module array_list_engine_core_test;

    import ale_pkg::*;

    localparam int LIST_DEPTH     = 128;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    // op codes the block answers without changing the list
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_op = OP_APPEND;
    logic [6:0]         s_position = '0;
    logic signed [31:0] s_element_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [6:0]         m_found_position;
    logic signed [31:0] m_read_value;
    logic [7:0]         m_count_after;

    // list image kept by the bench
    logic signed [31:0] list_mem [LIST_DEPTH];
    int                 list_len = 0;
    rsp_t               expected_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_asks  = 0;
    int hold_off_seen  = 0;
    int hold_off_left  = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    bit growing        = 1'b1;

    array_list_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_position       (s_position),
        .s_element_value  (s_element_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_read_value     (m_read_value),
        .m_count_after    (m_count_after)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // applies one request to the list image and returns its result
    function automatic rsp_t apply_request(logic [2:0] op, logic [6:0] pos,
                                           logic signed [31:0] val);
        rsp_t r;
        int   i;
        bit   hit;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        case (op)
            OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (int'(pos) > list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (i = list_len; i > int'(pos); i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (int'(pos) >= list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            OP_FIND: begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < list_len && !hit; i++) begin
                    if (list_mem[i] == val) begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.found_position = i[6:0];
                    end
                end
            end
            OP_READ: begin
                if (int'(pos) >= list_len)
                    r.status = ST_BAD_POS;
                else
                    r.read_value = list_mem[pos];
            end
            default: ;
        endcase
        r.count_after = list_len[7:0];
        return r;
    endfunction

    // mostly values already held or close to zero, so finds hit and repeat
    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50 && list_len > 0)
            return list_mem[$urandom_range(list_len - 1)];
        else if (roll < 80)
            return $signed(32'($urandom_range(7))) - 32'sd4;
        else if (roll < 90)
            return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        else
            return $urandom;
    endfunction

    // valid stays high from one transaction to the next unless the sender idles
    task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
                                input logic signed [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        expected_results.push_back(apply_request(op, pos, val));
        s_valid         <= 1'b1;
        s_op            <= op;
        s_position      <= pos;
        s_element_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t %s mismatch: expected %0h, actual %0h",
                     $time, field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // result checker and receiver stall control
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result transaction: status %0d count %0d",
                             $time, m_status, m_count_after);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_status));
                    check_field("found_position", 32'(want.found_position),
                                32'(m_found_position));
                    check_field("read_value", want.read_value, m_read_value);
                    check_field("count_after", 32'(want.count_after), 32'(m_count_after));
                end
            end
            if (hold_off_asks != hold_off_seen) begin
                hold_off_seen <= hold_off_asks;
                hold_off_left <= HOLD_OFF_CYCLES;
                m_ready       <= 1'b0;
            end else if (hold_off_left > 0) begin
                hold_off_left <= hold_off_left - 1;
                m_ready       <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_empty_list();
        send_request(OP_READ, 7'd0, 32'sd0);
        send_request(OP_READ, 7'd127, 32'sd0);
        send_request(OP_DELETE, 7'd0, 32'sd0);
        send_request(OP_FIND, 7'd0, 32'sd5);
        send_request(OP_INSERT, 7'd1, 32'sd9);
        send_request(OP_SPARE_5, 7'd0, 32'sd1);
        send_request(OP_SPARE_6, 7'd127, 32'sh7fff_ffff);
        send_request(OP_SPARE_7, 7'd64, 32'sh8000_0000);
    endtask

    task automatic test_list_edges();
        send_request(OP_APPEND, 7'd0, 32'sh8000_0000);
        send_request(OP_APPEND, 7'd127, 32'sh7fff_ffff);
        send_request(OP_APPEND, 7'd0, 32'sd0);
        send_request(OP_INSERT, 7'd0, -32'sd1);
        // position equal to the count behaves as append
        send_request(OP_INSERT, 7'd4, 32'sh7fff_ffff);
        send_request(OP_INSERT, 7'd6, 32'sd3);
        // duplicate value, first match wins
        send_request(OP_FIND, 7'd0, 32'sh7fff_ffff);
        send_request(OP_FIND, 7'd0, 32'sd12345);
        send_request(OP_READ, 7'd0, 32'sd0);
        send_request(OP_READ, 7'd4, 32'sd0);
        send_request(OP_READ, 7'd5, 32'sd0);
        send_request(OP_DELETE, 7'd5, 32'sd0);
        send_request(OP_DELETE, 7'd0, 32'sd0);
        send_request(OP_DELETE, 7'd3, 32'sd0);
        send_request(OP_FIND, 7'd0, -32'sd1);
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_back_pressure();
        hold_off_asks++;
        for (int k = 0; k < 10; k++)
            send_request(k[0] ? OP_READ : OP_APPEND, 7'($urandom_range(3)), pick_value());
    endtask

    // grows the list to capacity, lingers there, then drains it to empty
    task automatic test_random_traffic(input int n_items);
        logic [2:0]         op;
        logic [6:0]         pos;
        logic signed [31:0] val;
        int                 roll;
        for (int k = 0; k < n_items; k++) begin
            op  = 3'($urandom_range(7));
            pos = 7'($urandom_range(127));
            val = $urandom;
            roll = $urandom_range(99);
            if (roll >= 10) begin
                roll = $urandom_range(99);
                if (growing)
                    op = roll < 50 ? OP_APPEND : roll < 80 ? OP_INSERT :
                         roll < 85 ? OP_DELETE : roll < 92 ? OP_FIND : OP_READ;
                else
                    op = roll < 5 ? OP_APPEND : roll < 10 ? OP_INSERT :
                         roll < 70 ? OP_DELETE : roll < 85 ? OP_FIND : OP_READ;
                if (op == OP_INSERT)
                    pos = 7'($urandom_range(list_len > 127 ? 127 : list_len));
                else if (list_len > 0)
                    pos = 7'($urandom_range(list_len - 1));
                if ($urandom_range(3) != 0)
                    val = pick_value();
            end
            send_request(op, pos, val);
            if (growing && list_len == LIST_DEPTH && $urandom_range(7) == 0)
                growing = 1'b0;
            else if (!growing && list_len == 0 && $urandom_range(3) == 0)
                growing = 1'b1;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = 33;
        recv_stall_pct = 57;
        test_empty_list();
        test_list_edges();
        test_back_pressure();
        test_random_traffic(180);

        send_idle_pct  = 57;
        recv_stall_pct = 33;
        test_random_traffic(180);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(190);

        @(posedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        // a stray late result would still be caught here
        repeat (LIST_DEPTH + 16) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
